[sv/ptsq_pkg.sv]
// Shared types and constants for the priority task slot queue.
// No dependencies; used by ptsq_cell and priority_task_slot_queue.
package ptsq_pkg;

    // Default sizes
    localparam int SLOTS_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 16;

    // Port widths fixed by the request format
    localparam int HANDLE_PORT_W = 16;
    localparam int PRIO_W        = 8;
    localparam int STATUS_W      = 3;
    localparam int INDEX_PORT_W  = 4;

    // Request opcodes
    localparam logic OP_POST     = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_POSTED     = 3'd0,
        STATUS_FULL       = 3'd1,
        STATUS_DISPATCHED = 3'd2,
        STATUS_EMPTY      = 3'd3,
        STATUS_NONE       = 3'd4
    } status_t;

    // Scan token that walks the row of slot cells
    typedef struct packed {
        logic              valid;
        logic              free_found;
        logic              best_found;
        logic [PRIO_W-1:0] best_prio;
    } scan_t;

    // Broadcast update to the slot cells
    typedef struct packed {
        logic wr;
        logic clr;
    } commit_t;

endpackage

[sv/ptsq_cell.sv]
// One task slot: holds valid bit, handle and priority, and updates the
// passing scan token (first free slot, best priority so far). Uses ptsq_pkg.
module ptsq_cell
    import ptsq_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int IDX         = 0,
    localparam int IW         = $clog2(SLOTS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  scan_t                  scan_in,
    input  logic [IW-1:0]          free_idx_in,
    input  logic [IW-1:0]          best_idx_in,
    input  logic [HANDLE_BITS-1:0] best_handle_in,
    output scan_t                  scan_out,
    output logic [IW-1:0]          free_idx_out,
    output logic [IW-1:0]          best_idx_out,
    output logic [HANDLE_BITS-1:0] best_handle_out,
    input  commit_t                commit,
    input  logic [IW-1:0]          commit_idx,
    input  logic [HANDLE_BITS-1:0] commit_handle,
    input  logic [PRIO_W-1:0]      commit_prio
);

    logic                   used_reg, used_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [PRIO_W-1:0]      prio_reg;
    scan_t                  scan_reg, scan_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic [HANDLE_BITS-1:0] best_handle_reg, best_handle_next;
    logic                   hit;

    assign hit = (commit_idx == IW'(IDX));

    // Set or drop occupancy on a commit aimed at this slot
    always_comb
    begin
        used_next = used_reg;
        if (commit.wr && hit)
        begin
            used_next = 1'b1;
        end
        else if (commit.clr && hit)
        begin
            used_next = 1'b0;
        end
    end

    // Fold this slot into the scan token
    always_comb
    begin
        scan_next        = scan_in;
        free_idx_next    = free_idx_in;
        best_idx_next    = best_idx_in;
        best_handle_next = best_handle_in;
        if (!scan_in.free_found && !used_reg)
        begin
            scan_next.free_found = 1'b1;
            free_idx_next        = IW'(IDX);
        end
        // strict compare keeps the lowest index on ties and skips priority 0
        if (used_reg && (prio_reg > scan_in.best_prio))
        begin
            scan_next.best_found = 1'b1;
            scan_next.best_prio  = prio_reg;
            best_idx_next        = IW'(IDX);
            best_handle_next     = handle_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            scan_reg <= scan_next;
        end
    end

    // Slot payload and token payload
    always_ff @(posedge clk)
    begin
        if (commit.wr && hit)
        begin
            handle_reg <= commit_handle;
            prio_reg   <= commit_prio;
        end
        free_idx_reg    <= free_idx_next;
        best_idx_reg    <= best_idx_next;
        best_handle_reg <= best_handle_next;
    end

    assign scan_out        = scan_reg;
    assign free_idx_out    = free_idx_reg;
    assign best_idx_out    = best_idx_reg;
    assign best_handle_out = best_handle_reg;

endmodule

[sv/priority_task_slot_queue.sv]
// Priority task queue over a row of SLOTS slot cells. Uses ptsq_pkg, ptsq_cell.
// A scan token steps through one slot cell per cycle, then the update is committed once the
// output is free to take the result; a new request is taken only after the previous one has
// finished its scan and commit and the queue has returned to idle.
// A request is taken while an earlier result still waits on the output.
// Reset (rst_n, async, active low): all slots free, count zero, no result.
module priority_task_slot_queue
    import ptsq_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [HANDLE_PORT_W-1:0] task_handle,
    input  logic [PRIO_W-1:0]        task_priority,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [HANDLE_PORT_W-1:0] out_handle,
    output logic [INDEX_PORT_W-1:0]  slot_index
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   op_reg;
    logic [HANDLE_BITS-1:0] req_handle_reg;
    logic [PRIO_W-1:0]      req_prio_reg;
    scan_t                  fin_scan_reg;
    logic [IW-1:0]          fin_free_idx_reg;
    logic [IW-1:0]          fin_best_idx_reg;
    logic [HANDLE_BITS-1:0] fin_best_handle_reg;
    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg, status_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;
    logic [IW-1:0]          slot_index_reg, slot_index_next;

    logic                   in_accept;
    logic                   out_free;
    logic                   commit_go;
    logic                   scan_end;
    commit_t                commit;
    logic [IW-1:0]          commit_idx;

    scan_t                  chain_scan   [SLOTS+1];
    logic [IW-1:0]          chain_free   [SLOTS+1];
    logic [IW-1:0]          chain_best   [SLOTS+1];
    logic [HANDLE_BITS-1:0] chain_handle [SLOTS+1];

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign commit_go = (state_reg == ST_FIN) && out_free;
    assign scan_end  = (state_reg == ST_SCAN) && chain_scan[SLOTS].valid;

    // Launch a fresh token into the first cell
    always_comb
    begin
        chain_scan[0]       = '0;
        chain_scan[0].valid = in_accept;
        chain_free[0]       = '0;
        chain_best[0]       = '0;
        chain_handle[0]     = '0;
    end

    // Row of slot cells
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        ptsq_cell #(
            .SLOTS       (SLOTS),
            .HANDLE_BITS (HANDLE_BITS),
            .IDX         (g)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .scan_in         (chain_scan[g]),
            .free_idx_in     (chain_free[g]),
            .best_idx_in     (chain_best[g]),
            .best_handle_in  (chain_handle[g]),
            .scan_out        (chain_scan[g+1]),
            .free_idx_out    (chain_free[g+1]),
            .best_idx_out    (chain_best[g+1]),
            .best_handle_out (chain_handle[g+1]),
            .commit          (commit),
            .commit_idx      (commit_idx),
            .commit_handle   (req_handle_reg),
            .commit_prio     (req_prio_reg)
        );
    end

    // Decide the result and the slot update from the finished scan
    always_comb
    begin
        commit          = '0;
        commit_idx      = '0;
        count_next      = count_reg;
        status_next     = status_reg;
        out_handle_next = out_handle_reg;
        slot_index_next = slot_index_reg;
        out_valid_next  = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (commit_go)
        begin
            out_valid_next  = 1'b1;
            out_handle_next = '0;
            slot_index_next = '0;
            if (op_reg == OP_POST)
            begin
                if (fin_scan_reg.free_found)
                begin
                    commit.wr       = 1'b1;
                    commit_idx      = fin_free_idx_reg;
                    count_next      = count_reg + CW'(1);
                    status_next     = STATUS_POSTED;
                    slot_index_next = fin_free_idx_reg;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            else if (count_reg == '0)
            begin
                status_next = STATUS_EMPTY;
            end
            else if (fin_scan_reg.best_found)
            begin
                commit.clr      = 1'b1;
                commit_idx      = fin_best_idx_reg;
                count_next      = count_reg - CW'(1);
                status_next     = STATUS_DISPATCHED;
                out_handle_next = fin_best_handle_reg;
                slot_index_next = fin_best_idx_reg;
            end
            else
            begin
                status_next = STATUS_NONE;
            end
        end
    end

    // Sequence one request at a time
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (commit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold request, finished scan and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg         <= op;
            req_handle_reg <= HANDLE_BITS'(task_handle);
            req_prio_reg   <= task_priority;
        end
        if (scan_end)
        begin
            fin_scan_reg        <= chain_scan[SLOTS];
            fin_free_idx_reg    <= chain_free[SLOTS];
            fin_best_idx_reg    <= chain_best[SLOTS];
            fin_best_handle_reg <= chain_handle[SLOTS];
        end
        status_reg     <= status_next;
        out_handle_reg <= out_handle_next;
        slot_index_reg <= slot_index_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_handle = HANDLE_PORT_W'(out_handle_reg);
    assign slot_index = INDEX_PORT_W'(slot_index_reg);

endmodule

[tb/tb_priority_task_slot_queue.sv]
// Self-checking testbench for priority_task_slot_queue: directed table, then random requests.
// Depends on ptsq_pkg and the priority_task_slot_queue RTL; results are checked by an
// in-bench slot table predictor.
`timescale 1ns / 100ps

module tb_priority_task_slot_queue;
    import ptsq_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int RANDOM_COUNT = 600;

    typedef struct {
        status_t                  status;
        logic [HANDLE_PORT_W-1:0] handle;
        logic [INDEX_PORT_W-1:0]  index;
    } outcome_t;

    typedef struct {
        logic                     op;
        logic [HANDLE_PORT_W-1:0] handle;
        logic [PRIO_W-1:0]        prio;
        bit                       typed;
        outcome_t                 want;
    } script_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     op;
    logic [HANDLE_PORT_W-1:0] task_handle;
    logic [PRIO_W-1:0]        task_priority;
    logic                     out_valid;
    logic                     out_ready;
    logic [STATUS_W-1:0]      status;
    logic [HANDLE_PORT_W-1:0] out_handle;
    logic [INDEX_PORT_W-1:0]  slot_index;

    // Predicted slot table
    bit                       slot_busy [SLOTS];
    logic [HANDLE_PORT_W-1:0] slot_task [SLOTS];
    logic [PRIO_W-1:0]        slot_prio [SLOTS];
    int                       busy_count;

    outcome_t    pending_outcomes [$];
    script_row_t script [$];
    int          fault_count;
    int          burst_left;
    int          post_bias;
    logic [15:0] ready_pattern;
    int          ready_phase;

    priority_task_slot_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .task_handle   (task_handle),
        .task_priority (task_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_handle    (out_handle),
        .slot_index    (slot_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Advance the slot table by one request and return its outcome
    function automatic outcome_t predict_outcome(logic req_op, logic [HANDLE_PORT_W-1:0] req_handle,
                                                 logic [PRIO_W-1:0] req_prio);
        outcome_t          res;
        bit                done;
        int                best;
        logic [PRIO_W-1:0] best_prio;
        res.status = STATUS_FULL;
        res.handle = '0;
        res.index  = '0;
        done       = 1'b0;
        best       = -1;
        best_prio  = '0;
        if (req_op == OP_POST)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!done && !slot_busy[i])
                begin
                    done         = 1'b1;
                    slot_busy[i] = 1'b1;
                    slot_task[i] = req_handle;
                    slot_prio[i] = req_prio;
                    busy_count++;
                    res.status   = STATUS_POSTED;
                    res.index    = INDEX_PORT_W'(i);
                end
            end
        end
        else if (busy_count == 0)
        begin
            res.status = STATUS_EMPTY;
        end
        else
        begin
            // Strict compare keeps the lowest index on ties and skips priority zero
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_busy[i] && slot_prio[i] > best_prio)
                begin
                    best_prio = slot_prio[i];
                    best      = i;
                end
            end
            if (best >= 0)
            begin
                slot_busy[best] = 1'b0;
                busy_count--;
                res.status      = STATUS_DISPATCHED;
                res.handle      = slot_task[best];
                res.index       = INDEX_PORT_W'(best);
            end
            else
            begin
                res.status = STATUS_NONE;
            end
        end
        return res;
    endfunction

    function automatic void add_row(logic row_op, logic [HANDLE_PORT_W-1:0] row_handle,
                                    logic [PRIO_W-1:0] row_prio, bit row_typed,
                                    status_t want_status, logic [HANDLE_PORT_W-1:0] want_handle,
                                    logic [INDEX_PORT_W-1:0] want_index);
        script_row_t row;
        row.op          = row_op;
        row.handle      = row_handle;
        row.prio        = row_prio;
        row.typed       = row_typed;
        row.want.status = want_status;
        row.want.handle = want_handle;
        row.want.index  = want_index;
        script.push_back(row);
    endfunction

    // Insert a random gap at the end of each burst and pick the next burst's length and post bias
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
            case ($urandom_range(0, 2))
                0:       post_bias = 25;
                1:       post_bias = 50;
                default: post_bias = 75;
            endcase
        end
        burst_left--;
    endtask

    // Hold one request until accepted, then advance the predictor and record the expected outcome (table or predicted)
    task automatic send_request(logic req_op, logic [HANDLE_PORT_W-1:0] req_handle,
                                logic [PRIO_W-1:0] req_prio, bit typed, outcome_t want);
        outcome_t predicted;
        in_valid      <= 1'b1;
        op            <= req_op;
        task_handle   <= req_handle;
        task_priority <= req_prio;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_outcome(req_op, req_handle, req_prio);
        pending_outcomes.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Stall the result side on a rotating pattern; bit 0 bounds each stall
    always @(negedge clk)
    begin
        if (ready_phase == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                ready_pattern = 16'hFFFF;
            else
                ready_pattern = 16'($urandom()) | 16'h0001;
        end
        out_ready  <= ready_pattern[ready_phase % 16];
        ready_phase = (ready_phase + 1) % 64;
    end

    // Check each returned result against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result: status %0d, out_handle %0h, slot_index %0d",
                       status, out_handle, slot_index);
                fault_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fault_count++;
                end
                if (out_handle !== want.handle)
                begin
                    $error("out_handle: expected %0h, actual %0h", want.handle, out_handle);
                    fault_count++;
                end
                if (slot_index !== want.index)
                begin
                    $error("slot_index: expected %0d, actual %0d", want.index, slot_index);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        outcome_t                 none_typed;
        logic                     req_op;
        logic [HANDLE_PORT_W-1:0] req_handle;
        logic [PRIO_W-1:0]        req_prio;
        int                       zero_entries;
        int                       pick;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_POST;
        task_handle   = '0;
        task_priority = '0;
        out_ready     = 1'b0;
        ready_phase   = 0;
        ready_pattern = 16'hFFFF;
        fault_count   = 0;
        burst_left    = 0;
        post_bias     = 50;
        busy_count    = 0;
        none_typed    = '{STATUS_POSTED, '0, '0};
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_task[i] = '0;
            slot_prio[i] = '0;
        end

        // Directed table: empty, priority-zero only, extremes, ties, slot reuse, full table
        add_row(OP_DISPATCH, 16'h0000, 8'd0,   1, STATUS_EMPTY,      16'h0000, 4'd0);
        add_row(OP_POST,     16'h0000, 8'd0,   1, STATUS_POSTED,     16'h0000, 4'd0);
        add_row(OP_DISPATCH, 16'hFFFF, 8'hFF,  1, STATUS_NONE,       16'h0000, 4'd0);
        add_row(OP_POST,     16'hFFFF, 8'd255, 1, STATUS_POSTED,     16'h0000, 4'd1);
        add_row(OP_POST,     16'h1234, 8'd255, 1, STATUS_POSTED,     16'h0000, 4'd2);
        add_row(OP_DISPATCH, 16'h0000, 8'd0,   1, STATUS_DISPATCHED, 16'hFFFF, 4'd1);
        add_row(OP_POST,     16'hA5A5, 8'd1,   1, STATUS_POSTED,     16'h0000, 4'd1);
        for (int i = 3; i < SLOTS; i++)
            add_row(OP_POST, (i == 9) ? 16'h0000 : (16'h5A00 | 16'(i)), 8'(i * 13), 0,
                    STATUS_POSTED, 16'h0000, 4'd0);
        add_row(OP_POST,     16'hBEEF, 8'd200, 1, STATUS_FULL,       16'h0000, 4'd0);
        add_row(OP_DISPATCH, 16'h0000, 8'd0,   1, STATUS_DISPATCHED, 16'h1234, 4'd2);
        add_row(OP_DISPATCH, 16'h0000, 8'd0,   0, STATUS_POSTED,     16'h0000, 4'd0);
        add_row(OP_DISPATCH, 16'h0000, 8'd0,   0, STATUS_POSTED,     16'h0000, 4'd0);

        // Hold reset, then release it on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[k])
        begin
            pace_sender();
            send_request(script[k].op, script[k].handle, script[k].prio, script[k].typed,
                         script[k].want);
        end

        // Random requests; keep priority-zero entries few so the table keeps draining
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            pace_sender();
            zero_entries = 0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_busy[i] && slot_prio[i] == 0)
                    zero_entries++;
            req_op = ($urandom_range(0, 99) < post_bias) ? OP_POST : OP_DISPATCH;
            pick   = $urandom_range(0, 99);
            if (pick < 5 && zero_entries < 2)
                req_prio = 8'd0;
            else if (pick < 40)
                req_prio = 8'($urandom_range(1, 3));
            else if (pick < 48)
                req_prio = 8'd255;
            else
                req_prio = 8'($urandom_range(1, 255));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                req_handle = 16'h0000;
            else if (pick == 1)
                req_handle = 16'hFFFF;
            else
                req_handle = 16'($urandom_range(0, 65535));
            send_request(req_op, req_handle, req_prio, 0, none_typed);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then watch a little longer for strays
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/ptsq_pkg.sv
sv/ptsq_cell.sv
sv/priority_task_slot_queue.sv
tb/tb_priority_task_slot_queue.sv
